[rtl/core/rcfp_pkg.sv]
package rcfp_pkg;

   // Failsafe mode codes, shared by the global register and the per-channel field.
   localparam logic [1:0] FS_CUSTOM   = 2'd0;
   localparam logic [1:0] FS_HOLD     = 2'd1;
   localparam logic [1:0] FS_NO_PULSE = 2'd2;

   localparam int WORD_W = 11;

   localparam logic [WORD_W-1:0] WORD_MAX    = 11'd2047;
   localparam logic [WORD_W-1:0] WORD_FS_MAX = 11'd2046;
   localparam logic [WORD_W-1:0] WORD_FS_MIN = 11'd1;
   localparam logic [WORD_W-1:0] WORD_MIN    = 11'd0;

   // Scaling by 800/1000 is taken as 4/5; the divide by five uses this
   // reciprocal, 2^18 / 5 rounded up, exact for any dividend below 2^18.
   localparam logic [15:0] RECIP5       = 16'd52429;
   localparam int          RECIP5_SHIFT = 18;

   localparam logic signed [12:0] WORD_BIAS = 13'sd1024;

   typedef logic [WORD_W-1:0] word_type;

   // Payload of one input transfer, first field in the highest bits.
   typedef struct packed {
      logic [1:0]         channel_mode;
      logic signed [9:0]  center_offset;
      logic signed [11:0] channel_value;
   } item_type;

endpackage

[rtl/core/rcfp_word.sv]
module rcfp_word (
   input  rcfp_pkg::item_type item,
   input  logic               failsafe_frame,
   input  logic [1:0]         failsafe_mode,
   output rcfp_pkg::word_type word
);
   import rcfp_pkg::*;

   logic signed [12:0] sum;
   logic               neg;
   logic [12:0]        mag_full;
   logic [13:0]        mag_x4;
   logic [29:0]        prod;
   logic [11:0]        quot;
   logic signed [12:0] quot_s;
   logic signed [12:0] scaled;
   logic               hold;
   logic               no_pulse;

   // Value plus twice the centre offset, then its magnitude times four.
   assign sum      = {item.channel_value[11], item.channel_value}
                   + {{2{item.center_offset[9]}}, item.center_offset, 1'b0};
   assign neg      = sum[12];
   assign mag_full = neg ? 13'(-sum) : 13'(sum);
   assign mag_x4   = {mag_full[11:0], 2'b00};

   // Divide by five, truncating; the sign is restored afterwards so that
   // the result rounds toward zero.
   assign prod   = 30'(mag_x4) * 30'(RECIP5);
   assign quot   = prod[RECIP5_SHIFT +: 12];
   assign quot_s = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   assign scaled = quot_s + WORD_BIAS;

   assign hold     = (failsafe_mode == FS_HOLD) || (item.channel_mode == FS_HOLD);
   assign no_pulse = (failsafe_mode == FS_NO_PULSE) || (item.channel_mode == FS_NO_PULSE);

   always_comb begin
      if (!failsafe_frame) begin
         if (scaled < 13'sd0) begin
            word = WORD_MIN;
         end else if (scaled > $signed({2'b00, WORD_MAX})) begin
            word = WORD_MAX;
         end else begin
            word = scaled[WORD_W-1:0];
         end
      end else if (hold) begin
         word = WORD_MAX;
      end else if (no_pulse) begin
         word = WORD_MIN;
      end else if (scaled < $signed({2'b00, WORD_FS_MIN})) begin
         word = WORD_FS_MIN;
      end else if (scaled > $signed({2'b00, WORD_FS_MAX})) begin
         word = WORD_FS_MAX;
      end else begin
         word = scaled[WORD_W-1:0];
      end
   end

endmodule

[rtl/core/rc_channel_frame_packer_core.sv]
// Radio channel frame packer.
//
// Each transfer on the req_ channel carries one channel: its value, its
// centre offset and its per-channel failsafe mode in req_tdata, and the
// failsafe-frame flag in req_tuser. The channel is scaled and clamped to an
// 11-bit word, which is packed least significant bit first into a byte
// stream on the rsp_ channel. rsp_tlast marks the last byte caused by a
// channel and rsp_tuser marks the final byte of a block of CHANNELS channels.
// The global failsafe mode is written through csr_wr_en/csr_wr_data.
//
// Each channel passes the input register and then the output byte register.
// A channel yields one or two bytes and the single byte lane sets the rate:
// a new channel is taken every cycle in which the output holds at most one
// byte that is being taken, so bytes of successive channels leave back to
// back while the receiver takes them; a block of 16 channels gives 22 bytes.
// An input register and the output byte register decouple the channels, so
// a stalled receiver holds one buffered channel and then drops req_tready.
// Reset clears the packing residue, the channel count and the failsafe mode.
module rc_channel_frame_packer_core #(
   parameter int CHANNELS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // Input channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rcfp_pkg::item_type  req_tdata,  // channel_value[11:0], center_offset[21:12],
                                           // channel_mode[23:22]
   input  logic                req_tuser,  // failsafe_frame[0]
   // Result channel.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // data_byte[7:0]
   output logic                rsp_tlast,
   output logic                rsp_tuser,  // frame_end[0]
   // Configuration.
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data
);
   import rcfp_pkg::*;

   localparam int IDX_W = $clog2(CHANNELS);

   // Input register.
   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff;
   logic     in_fs_ff;

   // Configuration and packing state.
   logic [1:0]       mode_ff;
   logic [6:0]       res_bits_ff, res_bits_in;
   logic [2:0]       res_cnt_ff, res_cnt_in;
   logic [IDX_W-1:0] chan_idx_ff, chan_idx_in;

   // Output stage: up to two bytes of the current channel.
   logic [1:0] out_cnt_ff, out_cnt_in;
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff;
   logic       fend_ff;

   word_type   word;
   logic [17:0] acc;
   logic [4:0]  cnt;
   logic        two_bytes;
   logic        final_ch;
   logic        load;
   logic        req_xfer;
   logic        rsp_xfer;

   rcfp_word u_word (
      .item           (in_item_ff),
      .failsafe_frame (in_fs_ff),
      .failsafe_mode  (mode_ff),
      .word           (word)
   );

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // The buffered channel moves on once the output stage is empty or is
   // handing over its final byte in this cycle.
   assign load = in_valid_ff
              && ((out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_tready));

   assign req_tready = !in_valid_ff || load;
   assign req_xfer   = req_tvalid && req_tready;

   // Append the new word above the residue and split off whole bytes.
   assign acc       = {11'b0, res_bits_ff} | (18'(word) << res_cnt_ff);
   assign cnt       = {2'b00, res_cnt_ff} + 5'd11;
   assign two_bytes = cnt[4];
   assign final_ch  = (chan_idx_ff == IDX_W'(CHANNELS - 1));

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      res_bits_in = res_bits_ff;
      res_cnt_in  = res_cnt_ff;
      chan_idx_in = chan_idx_ff;
      if (load) begin
         if (final_ch) begin
            // Leftover bits of a block that is not byte aligned are dropped.
            res_bits_in = 7'd0;
            res_cnt_in  = 3'd0;
            chan_idx_in = '0;
         end else begin
            res_bits_in = two_bytes ? {5'b0, acc[17:16]} : acc[14:8];
            res_cnt_in  = cnt[2:0];
            chan_idx_in = chan_idx_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      byte0_in   = byte0_ff;
      if (load) begin
         out_cnt_in = two_bytes ? 2'd2 : 2'd1;
         byte0_in   = acc[7:0];
      end else if (rsp_xfer) begin
         out_cnt_in = out_cnt_ff - 2'd1;
         byte0_in   = byte1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= FS_CUSTOM;
         res_bits_ff <= 7'd0;
         res_cnt_ff  <= 3'd0;
         chan_idx_ff <= '0;
         out_cnt_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         res_bits_ff <= res_bits_in;
         res_cnt_ff  <= res_cnt_in;
         chan_idx_ff <= chan_idx_in;
         out_cnt_ff  <= out_cnt_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_tdata;
         in_fs_ff   <= req_tuser;
      end
      byte0_ff <= byte0_in;
      if (load) begin
         byte1_ff <= acc[15:8];
         fend_ff  <= final_ch;
      end
   end

   // The byte at the head is the channel's last when it is the only one left.
   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_tdata  = byte0_ff;
   assign rsp_tlast  = (out_cnt_ff == 2'd1);
   assign rsp_tuser  = (out_cnt_ff == 2'd1) && fend_ff;

endmodule

[tb/sv/rcfp_frame_checker.sv]
module rcfp_frame_checker #(
   parameter int CHANNELS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  rcfp_pkg::item_type req_tdata,
   input  logic               req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [7:0]         rsp_tdata,
   input  logic               rsp_tlast,
   input  logic               rsp_tuser,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   output int                 failures,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import rcfp_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       frame_end;
   } frame_byte_type;

   frame_byte_type expected_bytes[$];

   logic [1:0] global_mode;
   logic [6:0] carry_bits;
   logic [2:0] carry_count;
   logic [5:0] channel_pos;

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= 40) begin
         $display("%0t ns: mismatch, %s", $realtime, what);
      end
   endtask

   // Scaled and clamped 11-bit word of one channel.
   function automatic word_type channel_word_for(input logic fs, input item_type item);
      int scaled;
      scaled = (int'(item.channel_value) + 2 * int'(item.center_offset)) * 800 / 1000
               + 1024;
      if (!fs) begin
         if (scaled < 0) return WORD_MIN;
         if (scaled > 2047) return WORD_MAX;
         return word_type'(scaled);
      end
      if (global_mode == FS_HOLD || item.channel_mode == FS_HOLD) return WORD_MAX;
      if (global_mode == FS_NO_PULSE || item.channel_mode == FS_NO_PULSE) return WORD_MIN;
      if (scaled < 1) return WORD_FS_MIN;
      if (scaled > 2046) return WORD_FS_MAX;
      return word_type'(scaled);
   endfunction

   // Packs one channel word and queues the bytes it releases.
   task automatic pack_channel(input logic fs, input item_type item);
      logic [17:0]    acc;
      int             cnt;
      int             n;
      frame_byte_type staged[2];
      acc = 18'(carry_bits) | (18'(channel_word_for(fs, item)) << carry_count);
      cnt = int'(carry_count) + WORD_W;
      n   = 0;
      while (cnt >= 8 && n < 2) begin
         staged[n].data_byte = acc[7:0];
         staged[n].last      = 1'b0;
         staged[n].frame_end = 1'b0;
         acc = acc >> 8;
         cnt -= 8;
         n++;
      end
      staged[n-1].last = 1'b1;
      if (int'(channel_pos) + 1 >= CHANNELS) begin
         staged[n-1].frame_end = 1'b1;
         carry_bits  = '0;
         carry_count = '0;
         channel_pos = '0;
      end else begin
         carry_bits  = acc[6:0];
         carry_count = cnt[2:0];
         channel_pos = channel_pos + 6'd1;
      end
      for (int i = 0; i < n; i++) begin
         expected_bytes.push_back(staged[i]);
      end
   endtask

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         global_mode = FS_CUSTOM;
         carry_bits  = '0;
         carry_count = '0;
         channel_pos = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte 0x%02h with nothing expected", rsp_tdata));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data_byte) begin
                  report_mismatch($sformatf("data byte 0x%02h, expected 0x%02h",
                                            rsp_tdata, want.data_byte));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("tlast %b, expected %b", rsp_tlast, want.last));
               end
               if (rsp_tuser !== want.frame_end) begin
                  report_mismatch($sformatf("frame end %b, expected %b",
                                            rsp_tuser, want.frame_end));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pack_channel(req_tuser, req_tdata);
         end
         if (csr_wr_en) begin
            global_mode = csr_wr_data;
         end
      end
      pending <= expected_bytes.size();
   end

endmodule

[tb/sv/tb_rc_channel_frame_packer_core.sv]
module tb_rc_channel_frame_packer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rcfp_pkg::*;

   localparam int CHANNELS = 16;
   // The spare mode code, which the block is meant to treat as custom values.
   localparam logic [1:0] FS_SPARE = 2'd3;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 310;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_tvalid = 1'b0;
   logic     req_tready;
   item_type req_tdata = '0;
   logic     req_tuser = 1'b0;
   logic     rsp_tvalid;
   logic     rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic     rsp_tlast;
   logic     rsp_tuser;
   logic     csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = FS_CUSTOM;

   int failures;
   int pending;

   // Sender pacing: transfers left in the current burst, and the running
   // channel count used to keep failsafe flags constant over a frame.
   int burst_left = 0;
   int channels_sent = 0;
   logic frame_is_failsafe = 1'b0;

   always #5 clock = ~clock;

   rc_channel_frame_packer_core #(
      .CHANNELS(CHANNELS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rcfp_frame_checker #(
      .CHANNELS(CHANNELS)
   ) frame_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   // The receiver changes its stalling style every so often: always ready,
   // coin tosses, a fixed one-in-three pattern, or long stalls broken by a
   // single ready cycle. The always-ready style gives stretches of full rate.
   int stall_style = 0;
   int style_left = 0;
   int stall_left = 0;
   int pattern_tick = 0;

   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 3);
         style_left  = $urandom_range(40, 300);
      end else begin
         style_left--;
      end
      pattern_tick++;
      case (stall_style)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= (pattern_tick % 3 == 0);
         end
         default: begin
            if (stall_left == 0) begin
               stall_left = $urandom_range(1, 12);
               rsp_tready <= 1'b1;
            end else begin
               stall_left--;
               rsp_tready <= 1'b0;
            end
         end
      endcase
   end

   // Sends one channel. Entered and left at a falling edge. When a burst runs
   // out, tvalid drops for a random gap before the next burst starts; most
   // bursts are short, a few are long enough to keep the input busy.
   task automatic send_channel(input logic fs, input int value, input int offset,
                               input logic [1:0] mode);
      item_type item;
      int       gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
      end
      item.channel_value = 12'(value);
      item.center_offset = 10'(offset);
      item.channel_mode  = mode;
      req_tdata  = item;
      req_tuser  = fs;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      channels_sent++;
   endtask

   // The global mode is changed only once every expected byte has come out,
   // plus a short margin for the block to settle.
   task automatic set_global_mode(input logic [1:0] mode);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Channel values cluster on the nominal throw and its ends, with fully
   // random words mixed in so that every bit toggles.
   function automatic int pick_value();
      case ($urandom_range(0, 9))
         0: return -2048;
         1: return 2047;
         2: return $urandom_range(0, 40) - 1044;
         3: return $urandom_range(0, 40) + 1004;
         4, 5: return int'($signed(12'($urandom)));
         default: return int'($urandom_range(0, 2048)) - 1024;
      endcase
   endfunction

   function automatic int pick_offset();
      case ($urandom_range(0, 7))
         0: return -512;
         1: return 511;
         2, 3: return int'($signed(10'($urandom)));
         default: return int'($urandom_range(0, 80)) - 40;
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      case ($urandom_range(0, 7))
         0: return FS_HOLD;
         1: return FS_NO_PULSE;
         2: return FS_SPARE;
         default: return FS_CUSTOM;
      endcase
   endfunction

   // Random channels grouped into frames. The failsafe flag is chosen once
   // per frame, as a transmitter would, with the odd channel flipped to see
   // that the block treats the flag per transfer.
   task automatic send_random_channels(input int count);
      logic fs;
      for (int i = 0; i < count; i++) begin
         if (channels_sent % CHANNELS == 0) begin
            frame_is_failsafe = ($urandom_range(0, 2) == 0);
         end
         fs = frame_is_failsafe;
         if ($urandom_range(0, 19) == 0) begin
            fs = ~fs;
         end
         send_channel(fs, pick_value(), pick_offset(), pick_mode());
      end
   endtask

   initial begin
      logic [1:0] phase_modes[RANDOM_PHASES];
      phase_modes = '{FS_NO_PULSE, FS_HOLD, FS_SPARE, FS_CUSTOM, FS_HOLD, FS_NO_PULSE};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed channels, first under the reset mode of custom values. The
      // first sixteen make up a whole frame, so its end is seen early.
      send_channel(1'b0, 0, 0, FS_CUSTOM);              // centre word
      send_channel(1'b0, 2047, 511, FS_CUSTOM);         // clamps at the top
      send_channel(1'b0, -2048, -512, FS_CUSTOM);       // clamps at the bottom
      send_channel(1'b0, 1024, 0, FS_CUSTOM);           // full throw up
      send_channel(1'b0, -1024, 0, FS_CUSTOM);          // full throw down
      send_channel(1'b0, -2, 0, FS_CUSTOM);             // truncation towards zero
      send_channel(1'b0, -3, 1, FS_CUSTOM);             // offset added twice
      send_channel(1'b0, 100, 0, FS_HOLD);              // modes ignored in a normal frame
      send_channel(1'b0, 100, 0, FS_NO_PULSE);
      send_channel(1'b1, 2047, 511, FS_CUSTOM);         // failsafe clamp at the top
      send_channel(1'b1, -2048, -512, FS_CUSTOM);       // failsafe clamp at the bottom
      send_channel(1'b1, 300, 0, FS_HOLD);
      send_channel(1'b1, 300, 0, FS_NO_PULSE);
      send_channel(1'b1, 500, 0, FS_SPARE);             // spare mode uses the value
      send_channel(1'b1, 0, -511, FS_CUSTOM);
      send_channel(1'b0, 1279, 0, FS_CUSTOM);           // last channel of the frame

      // Global no pulses: hold on the channel still wins.
      set_global_mode(FS_NO_PULSE);
      send_channel(1'b1, 700, 10, FS_CUSTOM);
      send_channel(1'b1, 700, 10, FS_HOLD);
      send_channel(1'b0, 300, 0, FS_CUSTOM);

      // Global hold overrides a per-channel no pulses.
      set_global_mode(FS_HOLD);
      send_channel(1'b1, -700, 0, FS_NO_PULSE);
      send_channel(1'b1, -700, 0, FS_CUSTOM);

      // The spare global code behaves as custom values.
      set_global_mode(FS_SPARE);
      send_channel(1'b1, 700, -20, FS_CUSTOM);
      send_channel(1'b1, 700, -20, FS_NO_PULSE);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_global_mode(phase_modes[p]);
         send_random_channels(ITEMS_PER_PHASE);
      end

      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (failures == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rcfp_pkg.sv
rtl/core/rcfp_word.sv
rtl/core/rc_channel_frame_packer_core.sv
tb/sv/rcfp_frame_checker.sv
tb/sv/tb_rc_channel_frame_packer_core.sv
